// ===== design/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-button debouncer package
// Command and register codes and the result word type of the debouncer.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int MASK_BITS  = 8;
    localparam int COUNT_BITS = 8;
    localparam int ACTIVE_BITS = 4;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE_MASK    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INIT_LEVELS    = 2'd2;

    localparam logic [COUNT_BITS-1:0] TICKS_RESET = 8'd16;

    typedef struct packed {
        logic [MASK_BITS-1:0]   changed_mask;
        logic [MASK_BITS-1:0]   stable_levels;
        logic                   busy_res;
        logic [ACTIVE_BITS-1:0] active_count;
    } result_t;

endpackage

// ===== design/multi_button_debouncer_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-button debouncer
// Restart-on-edge countdown debouncer for up to eight buttons.
// ----------------------------------------------------------------------------
// Each input word is either an edge on one button, which starts or restarts
// that button's countdown, or a tick carrying the live pin levels, which
// advances every running countdown. A button whose countdown expires on a
// tick samples its pin, and if it is enabled and the level differs from its
// stable level, the stable level is updated and its change bit is set.
// Every accepted word yields exactly one result word on the m_ channel.
// The result is registered in the output register, or in the skid entry when
// the output is held, and one word is accepted per cycle while s_ready is high;
// all lanes update in parallel. A two-entry output buffer lets the block
// take a new word while a finished result is still waiting; s_ready drops
// only when both entries are full because the receiver holds m_ready low.
// Reset stops all countdowns, sets debounce_ticks to 16, and clears
// enable_mask and the stable levels. Configuration writes through cfg_wr_en
// take effect at once; a write to init_levels overwrites the stable levels.
// ----------------------------------------------------------------------------
module multi_button_debouncer_unit #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mbd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mbd_pkg::COUNT_BITS-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [2:0]                          s_button_index,
    input  logic [mbd_pkg::MASK_BITS-1:0]       s_pin_levels,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mbd_pkg::MASK_BITS-1:0]       m_changed_mask,
    output logic [mbd_pkg::MASK_BITS-1:0]       m_stable_levels,
    output logic                                m_busy_res,
    output logic [mbd_pkg::ACTIVE_BITS-1:0]     m_active_count
);

    localparam int LANES = (NUM_BUTTONS < mbd_pkg::MASK_BITS) ? NUM_BUTTONS
                                                              : mbd_pkg::MASK_BITS;
    localparam logic [mbd_pkg::MASK_BITS-1:0] LANE_MASK =
        mbd_pkg::MASK_BITS'((64'd1 << LANES) - 64'd1);

    logic [mbd_pkg::COUNT_BITS-1:0] ticks_reg;
    logic [mbd_pkg::MASK_BITS-1:0]  enable_reg;
    logic [LANES-1:0]               counting_reg;
    logic [LANES-1:0]               counting_next;
    logic [mbd_pkg::COUNT_BITS-1:0] countdown_reg  [LANES];
    logic [mbd_pkg::COUNT_BITS-1:0] countdown_next [LANES];
    logic [mbd_pkg::MASK_BITS-1:0]  stable_reg;
    logic [mbd_pkg::MASK_BITS-1:0]  stable_next;
    logic [mbd_pkg::MASK_BITS-1:0]  changed_next;
    logic [mbd_pkg::ACTIVE_BITS-1:0] active_next;

    mbd_pkg::result_t result_next;
    mbd_pkg::result_t out_reg;
    mbd_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             accept;
    logic             out_free;

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        logic [mbd_pkg::COUNT_BITS-1:0] dec;
        logic                           expire;
        logic                           start;
        counting_next = counting_reg;
        stable_next   = stable_reg;
        changed_next  = '0;
        active_next   = '0;
        for (int b = 0; b < LANES; b++) begin
            dec    = countdown_reg[b] - 8'd1;
            start  = (s_cmd == mbd_pkg::CMD_EDGE) && (int'(s_button_index) == b);
            expire = (s_cmd == mbd_pkg::CMD_TICK) && counting_reg[b] && (dec == '0);
            countdown_next[b] = countdown_reg[b];
            if (start) begin
                counting_next[b]  = 1'b1;
                countdown_next[b] = ticks_reg;
            end else if ((s_cmd == mbd_pkg::CMD_TICK) && counting_reg[b]) begin
                if (expire) begin
                    counting_next[b]  = 1'b0;
                    countdown_next[b] = ticks_reg;
                    if (enable_reg[b] && (s_pin_levels[b] != stable_reg[b])) begin
                        stable_next[b]  = s_pin_levels[b];
                        changed_next[b] = 1'b1;
                    end
                end else begin
                    countdown_next[b] = dec;
                end
            end
            active_next = active_next + mbd_pkg::ACTIVE_BITS'(counting_next[b]);
        end
        result_next.changed_mask  = changed_next;
        result_next.stable_levels = stable_next;
        result_next.busy_res      = (active_next != '0);
        result_next.active_count  = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg    <= mbd_pkg::TICKS_RESET;
            enable_reg   <= '0;
            stable_reg   <= '0;
            counting_reg <= '0;
            for (int b = 0; b < LANES; b++) begin
                countdown_reg[b] <= mbd_pkg::TICKS_RESET;
            end
        end else begin
            if (accept) begin
                counting_reg <= counting_next;
                stable_reg   <= stable_next;
                for (int b = 0; b < LANES; b++) begin
                    countdown_reg[b] <= countdown_next[b];
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    mbd_pkg::REG_DEBOUNCE_TICKS: ticks_reg  <= cfg_wdata;
                    mbd_pkg::REG_ENABLE_MASK:    enable_reg <= cfg_wdata;
                    mbd_pkg::REG_INIT_LEVELS:    stable_reg <= cfg_wdata & LANE_MASK;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result_next;
            end
        end else if (accept) begin
            skid_reg <= result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_changed_mask  = out_reg.changed_mask;
    assign m_stable_levels = out_reg.stable_levels;
    assign m_busy_res      = out_reg.busy_res;
    assign m_active_count  = out_reg.active_count;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry holds a word while the output entry is empty.");

    a_busy_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.busy_res == (out_reg.active_count != '0)))
        else $error("Busy flag disagrees with the active count.");

    a_changed_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ((out_reg.changed_mask & ~enable_reg) == '0) || skid_valid_reg)
        else $error("A disabled button reported a change.");

    a_stable_in_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        (stable_reg & ~LANE_MASK) == '0)
        else $error("Stable level set on a button that does not exist.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (int'(out_reg.active_count) <= LANES))
        else $error("Active count exceeds the number of buttons.");
`endif

endmodule

// ===== tb/mbd_level_checker.sv =====
// ----------------------------------------------------------------------------
// Multi-button debouncer result checker
// Watches the configuration port and both channels of the debouncer. It keeps
// its own copy of the countdowns, stable levels and registers, predicts the
// result word of every accepted input word, and compares each accepted result
// word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mbd_level_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mbd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mbd_pkg::COUNT_BITS-1:0]      cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [2:0]                          s_button_index,
    input  logic [mbd_pkg::MASK_BITS-1:0]       s_pin_levels,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [mbd_pkg::MASK_BITS-1:0]       m_changed_mask,
    input  logic [mbd_pkg::MASK_BITS-1:0]       m_stable_levels,
    input  logic                                m_busy_res,
    input  logic [mbd_pkg::ACTIVE_BITS-1:0]     m_active_count,
    output int                                  fail_count,
    output int                                  pending_words
);

    localparam int NUM_LANES = mbd_pkg::MASK_BITS;

    logic [mbd_pkg::COUNT_BITS-1:0] ticks_cfg;
    logic [mbd_pkg::MASK_BITS-1:0]  enable_cfg;
    logic [NUM_LANES-1:0]           counting_q;
    logic [mbd_pkg::COUNT_BITS-1:0] countdown_q [NUM_LANES];
    logic [mbd_pkg::MASK_BITS-1:0]  stable_q;
    mbd_pkg::result_t               expected_levels_q [$];
    int                             errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic clear_debounce();
        int b;
        ticks_cfg  = mbd_pkg::TICKS_RESET;
        enable_cfg = '0;
        stable_q   = '0;
        counting_q = '0;
        for (b = 0; b < NUM_LANES; b++) begin
            countdown_q[b] = mbd_pkg::TICKS_RESET;
        end
        expected_levels_q.delete();
    endtask

    task automatic advance_debounce(input logic cmd, input logic [2:0] idx,
                                    input logic [mbd_pkg::MASK_BITS-1:0] pins,
                                    output mbd_pkg::result_t res);
        int b;
        int active;
        logic [mbd_pkg::MASK_BITS-1:0] changed;
        changed = '0;
        active = 0;
        if (cmd == mbd_pkg::CMD_EDGE) begin
            counting_q[idx]  = 1'b1;
            countdown_q[idx] = ticks_cfg;
        end else begin
            for (b = 0; b < NUM_LANES; b++) begin
                if (counting_q[b]) begin
                    countdown_q[b] = countdown_q[b] - 8'd1;
                    if (countdown_q[b] == '0) begin
                        counting_q[b]  = 1'b0;
                        countdown_q[b] = ticks_cfg;
                        if (enable_cfg[b] && (pins[b] != stable_q[b])) begin
                            stable_q[b] = pins[b];
                            changed[b]  = 1'b1;
                        end
                    end
                end
            end
        end
        for (b = 0; b < NUM_LANES; b++) begin
            if (counting_q[b]) begin
                active++;
            end
        end
        res.changed_mask  = changed;
        res.stable_levels = stable_q;
        res.busy_res      = (active > 0);
        res.active_count  = mbd_pkg::ACTIVE_BITS'(active);
    endtask

    always @(posedge aclk) begin
        mbd_pkg::result_t want;
        mbd_pkg::result_t got;
        if (!aresetn) begin
            clear_debounce();
        end else begin
            if (m_valid && m_ready) begin
                got.changed_mask  = m_changed_mask;
                got.stable_levels = m_stable_levels;
                got.busy_res      = m_busy_res;
                got.active_count  = m_active_count;
                if (expected_levels_q.size() == 0) begin
                    report_mismatch($sformatf("result word %0h with none expected", got));
                end else begin
                    want = expected_levels_q.pop_front();
                    if (got.changed_mask !== want.changed_mask) begin
                        report_mismatch($sformatf("changed_mask got %0h expected %0h",
                                                  got.changed_mask, want.changed_mask));
                    end
                    if (got.stable_levels !== want.stable_levels) begin
                        report_mismatch($sformatf("stable_levels got %0h expected %0h",
                                                  got.stable_levels, want.stable_levels));
                    end
                    if (got.busy_res !== want.busy_res) begin
                        report_mismatch($sformatf("busy_res got %0b expected %0b",
                                                  got.busy_res, want.busy_res));
                    end
                    if (got.active_count !== want.active_count) begin
                        report_mismatch($sformatf("active_count got %0d expected %0d",
                                                  got.active_count, want.active_count));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    mbd_pkg::REG_DEBOUNCE_TICKS: ticks_cfg = cfg_wdata;
                    mbd_pkg::REG_ENABLE_MASK: enable_cfg = cfg_wdata;
                    mbd_pkg::REG_INIT_LEVELS: stable_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_debounce(s_cmd, s_button_index, s_pin_levels, want);
                expected_levels_q.push_back(want);
            end
        end
        pending_words <= expected_levels_q.size();
    end

endmodule

// ===== tb/multi_button_debouncer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Multi-button debouncer testbench
// Drives edge and tick words into the debouncer under several register
// settings and several idling patterns, including a long receiver hold-off
// that fills the block, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module multi_button_debouncer_unit_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 40;
    localparam int NUM_PHASES = 7;

    logic                                aclk;
    logic                                aresetn = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [mbd_pkg::CFG_INDEX_BITS-1:0]  cfg_index = mbd_pkg::REG_DEBOUNCE_TICKS;
    logic [mbd_pkg::COUNT_BITS-1:0]      cfg_wdata = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic                                s_cmd = mbd_pkg::CMD_EDGE;
    logic [2:0]                          s_button_index = '0;
    logic [mbd_pkg::MASK_BITS-1:0]       s_pin_levels = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [mbd_pkg::MASK_BITS-1:0]       m_changed_mask;
    logic [mbd_pkg::MASK_BITS-1:0]       m_stable_levels;
    logic                                m_busy_res;
    logic [mbd_pkg::ACTIVE_BITS-1:0]     m_active_count;
    int                                  fail_count;
    int                                  pending_words;

    int src_idle = 0;
    int snk_stall = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    multi_button_debouncer_unit #(
        .NUM_BUTTONS(8)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_button_index(s_button_index),
        .s_pin_levels(s_pin_levels),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_changed_mask(m_changed_mask),
        .m_stable_levels(m_stable_levels),
        .m_busy_res(m_busy_res),
        .m_active_count(m_active_count)
    );

    mbd_level_checker checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_button_index(s_button_index),
        .s_pin_levels(s_pin_levels),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_changed_mask(m_changed_mask),
        .m_stable_levels(m_stable_levels),
        .m_busy_res(m_busy_res),
        .m_active_count(m_active_count),
        .fail_count(fail_count),
        .pending_words(pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_word(input logic cmd, input logic [2:0] idx,
                             input logic [mbd_pkg::MASK_BITS-1:0] pins);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_button_index <= idx;
        s_pin_levels <= pins;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic program_regs(input logic [mbd_pkg::COUNT_BITS-1:0] ticks,
                                input logic [mbd_pkg::MASK_BITS-1:0] en,
                                input logic [mbd_pkg::MASK_BITS-1:0] init);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= mbd_pkg::REG_DEBOUNCE_TICKS;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_index <= mbd_pkg::REG_ENABLE_MASK;
        cfg_wdata <= en;
        @(posedge aclk);
        cfg_index <= mbd_pkg::REG_INIT_LEVELS;
        cfg_wdata <= init;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Most words come as a few edges followed by a run of ticks of random length,
    // which may end before the countdowns expire; the rest are single random words.
    task automatic run_phase(input int n_words, input int tick_len);
        int sent;
        int burst;
        int k;
        logic [2:0] idx;
        logic [mbd_pkg::MASK_BITS-1:0] pins;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 80) begin
                burst = $urandom_range(3, 1);
                for (k = 0; k < burst; k++) begin
                    idx = 3'($urandom_range(7));
                    push_word(mbd_pkg::CMD_EDGE, idx, mbd_pkg::MASK_BITS'($urandom));
                    sent++;
                end
                pins = mbd_pkg::MASK_BITS'($urandom);
                burst = $urandom_range(tick_len + 2);
                for (k = 0; k < burst; k++) begin
                    if ($urandom_range(3) == 0) begin
                        pins = mbd_pkg::MASK_BITS'($urandom);
                    end
                    idx = 3'($urandom_range(7));
                    push_word(mbd_pkg::CMD_TICK, idx, pins);
                    sent++;
                end
            end else begin
                idx = 3'($urandom_range(7));
                push_word(1'($urandom_range(1)), idx, mbd_pkg::MASK_BITS'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        logic [mbd_pkg::COUNT_BITS-1:0] ph_ticks [NUM_PHASES];
        logic [mbd_pkg::MASK_BITS-1:0]  ph_en [NUM_PHASES];
        logic [mbd_pkg::MASK_BITS-1:0]  ph_init [NUM_PHASES];
        int p;
        int k;
        int tick_len;
        ph_ticks = '{8'd3, 8'd1, 8'd5, 8'd255, 8'd2, 8'd0, 8'd8};
        ph_en = '{8'hFF, 8'h5A, 8'h00, 8'hFF, 8'h3C, 8'hA5, 8'hFF};
        ph_init = '{8'h00, 8'hFF, 8'h96, 8'h0F, 8'hF0, 8'h00, 8'hFF};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: sixteen ticks, nothing enabled.
        push_word(mbd_pkg::CMD_EDGE, 3'd1, 8'h00);
        for (k = 0; k < 16; k++) begin
            push_word(mbd_pkg::CMD_TICK, 3'd0, 8'hFF);
        end

        // Restart on a repeated edge, lowest and highest button, no-op tick.
        program_regs(8'd2, 8'hFF, 8'h0F);
        push_word(mbd_pkg::CMD_TICK, 3'd7, 8'h00);
        push_word(mbd_pkg::CMD_EDGE, 3'd0, 8'hFF);
        push_word(mbd_pkg::CMD_EDGE, 3'd7, 8'h00);
        push_word(mbd_pkg::CMD_EDGE, 3'd0, 8'h00);
        push_word(mbd_pkg::CMD_TICK, 3'd0, 8'hFF);
        push_word(mbd_pkg::CMD_TICK, 3'd0, 8'hFF);

        // A disabled button expires without a change.
        program_regs(8'd2, 8'h0F, 8'h0F);
        push_word(mbd_pkg::CMD_EDGE, 3'd3, 8'h00);
        push_word(mbd_pkg::CMD_EDGE, 3'd4, 8'h00);
        push_word(mbd_pkg::CMD_TICK, 3'd0, 8'h00);
        push_word(mbd_pkg::CMD_TICK, 3'd0, 8'h00);

        // A running countdown keeps its value across a tick length write.
        push_word(mbd_pkg::CMD_EDGE, 3'd5, 8'h00);
        program_regs(8'd5, 8'hFF, 8'h00);
        push_word(mbd_pkg::CMD_TICK, 3'd0, 8'h20);
        push_word(mbd_pkg::CMD_TICK, 3'd0, 8'h20);

        for (p = 0; p < NUM_PHASES; p++) begin
            program_regs(ph_ticks[p], ph_en[p], ph_init[p]);
            case (p % 4)
                0: begin
                    src_idle = 0;
                    snk_stall = 0;
                end
                1: begin
                    src_idle = 69;
                    snk_stall = 0;
                end
                2: begin
                    src_idle = 0;
                    snk_stall = 69;
                end
                default: begin
                    src_idle = 30;
                    snk_stall = 30;
                end
            endcase
            if (p == 0) begin
                hold_req = 1'b1;
            end
            tick_len = (ph_ticks[p] == '0) ? 256 : int'(ph_ticks[p]);
            run_phase((tick_len > 100) ? 200 : 120, tick_len);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
